>>> hdl/crc16fg_pkg.sv
// Shared types and constants for the CRC-16 frame generator / checker.
package crc16fg_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] POLY_RESET    = 16'hA001;
  localparam int          QUEUE_DEPTH_D = 4;

  // Register indexes on the configuration port.
  localparam logic REG_POLY = 1'b0;
  localparam logic REG_MODE = 1'b1;

  // Output beat kinds.
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CRC     = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  typedef enum logic [1:0] {
    JOB_ECHO,
    JOB_APPEND,
    JOB_VERDICT
  } job_op_t;

  // One queued unit of back-end work: one or three output beats.
  typedef struct packed {
    job_op_t     op;
    logic [7:0]  data;
    logic [15:0] crc;
    logic        ok;
  } job_t;

endpackage

>>> hdl/crc16fg_front.sv
// Front end: accepts frame bytes, runs the CRC and hold window, emits jobs.
module crc16fg_front import crc16fg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  input  logic [15:0] polynomial,
  input  logic        mode,
  input  logic        queue_full,
  output logic        job_push,
  output job_t        job
);

  logic [15:0] crc_value, crc_value_next;
  logic [7:0]  held_older, held_older_next;
  logic [7:0]  held_newer, held_newer_next;
  logic [1:0]  held_count, held_count_next;
  logic        accept;
  logic [15:0] crc_in_byte, crc_in_older, crc_chk;
  logic [1:0]  cnt_chk;

  // One byte through the reflected CRC: eight shift/xor steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = {1'b0, c[15:1]} ^ poly;
      else      c = {1'b0, c[15:1]};
    end
    return c;
  endfunction

  assign in_ready     = !queue_full;
  assign accept       = in_valid && in_ready;
  assign crc_in_byte  = crc_byte(crc_value, data_byte, polynomial);
  assign crc_in_older = crc_byte(crc_value, held_older, polynomial);
  assign crc_chk      = (held_count == 2'd2) ? crc_in_older : crc_value;
  assign cnt_chk      = ((held_count == 2'd2) ? 2'd1 : held_count) + 2'd1;

  always_comb begin
    crc_value_next  = crc_value;
    held_older_next = held_older;
    held_newer_next = held_newer;
    held_count_next = held_count;
    job_push        = 1'b0;
    job.op          = JOB_ECHO;
    job.data        = data_byte;
    job.crc         = crc_in_byte;
    job.ok          = 1'b0;
    if (accept) begin
      if (!mode) begin
        job_push       = 1'b1;
        job.op         = frame_end ? JOB_APPEND : JOB_ECHO;
        crc_value_next = crc_in_byte;
      end else begin
        crc_value_next  = crc_chk;
        held_older_next = held_newer;
        held_newer_next = data_byte;
        held_count_next = cnt_chk;
        if (frame_end) begin
          job_push = 1'b1;
          job.op   = JOB_VERDICT;
          job.data = 8'h00;
          job.ok   = (cnt_chk == 2'd2) && (held_newer == crc_chk[7:0]) &&
                     (data_byte == crc_chk[15:8]);
        end
      end
      // Drop the frame state once the frame closes.
      if (frame_end) begin
        crc_value_next  = CRC_INIT;
        held_older_next = 8'h00;
        held_newer_next = 8'h00;
        held_count_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value  <= CRC_INIT;
      held_older <= 8'h00;
      held_newer <= 8'h00;
      held_count <= 2'd0;
    end else begin
      crc_value  <= crc_value_next;
      held_older <= held_older_next;
      held_newer <= held_newer_next;
      held_count <= held_count_next;
    end
  end

endmodule

>>> hdl/crc16fg_queue.sv
// Small job FIFO between the front and back ends.
module crc16fg_queue import crc16fg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_D
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/crc16fg_back.sv
// Back end: expands queued jobs into output beats through an output register.
module crc16fg_back import crc16fg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       head_job,
  input  logic       queue_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       crc_ok,
  output logic       run_last
);

  logic [1:0] beat_idx;
  logic       load;
  logic [1:0] b_kind;
  logic [7:0] b_byte;
  logic       b_ok, b_last;

  assign load = !queue_empty && (!out_valid || out_ready);
  assign pop  = load && b_last;

  always_comb begin
    b_kind = KIND_DATA;
    b_byte = head_job.data;
    b_ok   = 1'b0;
    b_last = 1'b1;
    unique case (head_job.op)
      JOB_ECHO: begin
        b_last = 1'b1;
      end
      JOB_APPEND: begin
        priority case (beat_idx)
          2'd0: begin
            b_last = 1'b0;
          end
          2'd1: begin
            b_kind = KIND_CRC;
            b_byte = head_job.crc[7:0];
            b_last = 1'b0;
          end
          default: begin
            b_kind = KIND_CRC;
            b_byte = head_job.crc[15:8];
          end
        endcase
      end
      JOB_VERDICT: begin
        b_kind = KIND_VERDICT;
        b_byte = 8'h00;
        b_ok   = head_job.ok;
      end
      default: begin
        b_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat_idx  <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat_idx  <= b_last ? 2'd0 : beat_idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind     <= b_kind;
      out_byte <= b_byte;
      crc_ok   <= b_ok;
      run_last <= b_last;
    end
  end

endmodule

>>> hdl/crc16_frame_generate_check.sv
// Top level of the CRC-16 frame generator / checker with its register port.
//
//   channel | direction | handshake            | beat payload
//   --------+-----------+----------------------+----------------------------------
//   in      | input     | in_valid / in_ready  | data_byte, frame_end
//   out     | output    | out_valid / out_ready| kind, out_byte, crc_ok, run_last
//   apb     | input     | psel/penable/pready  | paddr, pwdata, prdata
//
// One input beat is taken per cycle while the job queue has room; the
// eight-bit CRC update is combinational XOR logic in the front end.
// Output beats leave at one per cycle while out_ready holds high; a generate-mode
// frame end costs three output beats, so the output port sets the long-run rate then.
// Reset (rst, synchronous) loads polynomial 0xA001, generate mode, and an
// empty queue with the CRC at 0xFFFF. Each side stalls on its own: a stalled
// output fills the queue before in_ready drops.
module crc16_frame_generate_check import crc16fg_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  // output beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic        crc_ok,
  output logic        run_last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] polynomial;
  logic        mode;
  logic        reg_write;
  logic        job_push, job_pop, queue_full, queue_empty;
  job_t        push_job, head_job;

  // Registers sit at word addresses; paddr[2] picks the register.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= POLY_RESET;
      mode       <= 1'b0;
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_POLY: polynomial <= pwdata[15:0];
        REG_MODE: mode       <= pwdata[0];
        default:  mode       <= mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POLY: prdata = {16'h0000, polynomial};
      REG_MODE: prdata = {31'h0, mode};
      default:  prdata = 32'h0;
    endcase
  end

  // Front: classify each byte, advance the CRC and hold window.
  crc16fg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .polynomial (polynomial),
    .mode       (mode),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (push_job)
  );

  // Decouple the front from output stalls.
  crc16fg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  // Back: one beat per cycle out of the head job while out_ready is high.
  crc16fg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .queue_empty (queue_empty),
    .pop         (job_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_byte    (out_byte),
    .crc_ok      (crc_ok),
    .run_last    (run_last)
  );

endmodule

>>> hdl/crc16fg_checker.sv
// Port-level assertions for the CRC-16 frame generator / checker, with bind.
module crc16fg_checker import crc16fg_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic       crc_ok,
  input logic       run_last
);

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte) &&
                                $stable(crc_ok) && $stable(run_last))
    else $error("stalled output beat changed");

  // A verdict is a lone last beat with a zero byte.
  a_verdict_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_VERDICT |-> run_last && out_byte == 8'h00)
    else $error("malformed verdict beat");

  // Only verdicts carry crc_ok.
  a_ok_only_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_VERDICT |-> !crc_ok)
    else $error("crc_ok set on a data or CRC beat");

  // A non-final data beat is followed at once by the CRC low byte.
  a_data_then_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == KIND_DATA && !run_last |=>
      out_valid && kind == KIND_CRC && !run_last)
    else $error("CRC low byte did not follow frame-end data beat");

  // The CRC low byte is followed at once by the high byte.
  a_crc_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == KIND_CRC && !run_last |=>
      out_valid && kind == KIND_CRC && run_last)
    else $error("CRC high byte did not follow low byte");

endmodule

bind crc16_frame_generate_check crc16fg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_byte  (out_byte),
  .crc_ok    (crc_ok),
  .run_last  (run_last)
);
